>>> hw/rtl/cltt_pkg.sv
// ----------------------------------------------------------------------------
// cltt_pkg: shared types and constants of the character LCD text terminal
// Request codes, classified operation codes and the queue entry format.
// ----------------------------------------------------------------------------
package cltt_pkg;

    // Request kinds on the input stream
    localparam logic [1:0] REQ_PRINT   = 2'd0;
    localparam logic [1:0] REQ_GOTO    = 2'd1;
    localparam logic [1:0] REQ_SHIFT_R = 2'd2;
    localparam logic [1:0] REQ_SHIFT_L = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_TAB_WIDTH  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [5:0] LINE_WIDTH_RST = 6'd16;
    localparam logic [3:0] TAB_WIDTH_RST  = 4'd4;

    // Default depth of the queue between front and back
    localparam int CLTT_QUEUE_DEPTH = 2;

    // Operations handed from the front to the back
    typedef enum logic [3:0] {
        OP_PUT,
        OP_TAB,
        OP_NEWLINE,
        OP_RETURN,
        OP_VTAB,
        OP_FORMFEED,
        OP_BACKSPACE,
        OP_GOTO,
        OP_SHIFT_R,
        OP_SHIFT_L
    } t_op;

    // One queue entry
    typedef struct packed {
        t_op        op;
        logic [7:0] ch;    // character for OP_PUT
        logic       row;   // target row for OP_GOTO, 0 top
        logic [5:0] col;   // target column for OP_GOTO
    } t_cmd;

endpackage

>>> hw/rtl/char_lcd_text_terminal.sv
// ----------------------------------------------------------------------------
// char_lcd_text_terminal: two-line character LCD text terminal
// Turns print, go-to and shift requests into LCD bus bytes and tracks the
// cursor.
// ----------------------------------------------------------------------------
// A request passes through the intake stage and waits in a short
// queue (QUEUE_DEPTH entries) until the byte sequencer is free. The
// sequencer takes a command and then emits one bus byte per cycle while
// the output side is ready, 1 to 16 bytes; a backspace at column zero
// produces no transfer. Each output transfer carries one byte, tuser
// high for a data write and low for a command write, and tlast on the
// final byte of the request. Configuration writes go straight to the
// line and tab width registers and must be made while no request is in
// flight.
module char_lcd_text_terminal #(
    parameter int QUEUE_DEPTH = cltt_pkg::CLTT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,          // 0 line_width, 1 tab_width
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,     // char_code, target_row, target_col
    input  logic [1:0]  i_s_axis_tuser,     // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,     // lcd_byte
    output logic        o_m_axis_tuser,     // is_data
    output logic        o_m_axis_tlast      // last
);
    import cltt_pkg::*;

    logic w_f_valid, w_f_ready;
    t_cmd w_f_cmd;
    logic w_q_valid, w_q_ready;
    t_cmd w_q_cmd;

    cltt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (w_f_valid),
        .i_cmd_ready     (w_f_ready),
        .o_cmd           (w_f_cmd)
    );

    cltt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    cltt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_valid     (w_q_valid),
        .o_cmd_ready     (w_q_ready),
        .i_cmd           (w_q_cmd),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

>>> hw/rtl/cltt_front.sv
// ----------------------------------------------------------------------------
// cltt_front: request intake and classification
// Accepts request transfers and turns each into one queue entry.
// ----------------------------------------------------------------------------
module cltt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [15:0]   i_s_axis_tdata,   // char_code, target_row, target_col
    input  logic [1:0]    i_s_axis_tuser,   // req_type
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output cltt_pkg::t_cmd o_cmd
);
    import cltt_pkg::*;

    // Terminal control characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       w_cls;
    logic [7:0] w_ch;
    logic [1:0] w_row;

    assign w_ch  = i_s_axis_tdata[7:0];
    assign w_row = i_s_axis_tdata[9:8];

    // Holding stage frees up when the queue takes the entry
    assign o_s_axis_tready = !r_valid || i_cmd_ready;
    assign o_cmd_valid     = r_valid;
    assign o_cmd           = r_cmd;

    // Classify the request
    always_comb begin
        w_cls.ch  = w_ch;
        w_cls.row = (w_row != 2'd1);
        w_cls.col = i_s_axis_tdata[15:10];
        case (i_s_axis_tuser)
            REQ_PRINT: begin
                case (w_ch)
                    CH_NEWLINE:   w_cls.op = OP_NEWLINE;
                    CH_RETURN:    w_cls.op = OP_RETURN;
                    CH_VTAB:      w_cls.op = OP_VTAB;
                    CH_FORMFEED:  w_cls.op = OP_FORMFEED;
                    CH_BACKSPACE: w_cls.op = OP_BACKSPACE;
                    CH_TAB:       w_cls.op = OP_TAB;
                    default:      w_cls.op = OP_PUT;
                endcase
            end
            REQ_GOTO:    w_cls.op = OP_GOTO;
            REQ_SHIFT_R: w_cls.op = OP_SHIFT_R;
            default:     w_cls.op = OP_SHIFT_L;
        endcase
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_cmd <= w_cls;
        end
    end

endmodule

>>> hw/rtl/cltt_queue.sv
// ----------------------------------------------------------------------------
// cltt_queue: small command queue
// Register-based FIFO that decouples request intake from byte generation.
// ----------------------------------------------------------------------------
module cltt_queue #(
    parameter int DEPTH = cltt_pkg::CLTT_QUEUE_DEPTH   // 2 and up
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  cltt_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output cltt_pkg::t_cmd o_pop_cmd
);
    import cltt_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

>>> hw/rtl/cltt_back.sv
// ----------------------------------------------------------------------------
// cltt_back: byte sequencer
// Owns the cursor and configuration, runs one command at a time and emits
// its bus bytes through the output register.
// ----------------------------------------------------------------------------
module cltt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [5:0]     i_cfg_wdata,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  cltt_pkg::t_cmd i_cmd,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [7:0]     o_m_axis_tdata,   // lcd_byte
    output logic           o_m_axis_tuser,   // is_data
    output logic           o_m_axis_tlast
);
    import cltt_pkg::*;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW2_OFFSET  = 8'h40;
    localparam logic [7:0] CMD_SHIFT_R  = 8'h1C;
    localparam logic [7:0] CMD_SHIFT_L  = 8'h18;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [5:0] LINE_MAX     = 6'd40;
    localparam logic [3:0] TAB_MAX      = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_BS_ADDR1,
        S_BS_SPACE,
        S_BS_ADDR2,
        S_PUT,
        S_WRAP
    } t_state;

    // Set-address command for a cursor position
    function automatic logic [7:0] addr_cmd(input logic row, input logic [5:0] col);
        addr_cmd = CMD_SET_ADDR + (row ? ROW2_OFFSET : 8'h00) + {2'b00, col};
    endfunction

    t_state     r_state, n_state;
    logic       r_row, n_row;
    logic [5:0] r_col, n_col;
    logic [5:0] r_line_width, n_line_width;
    logic [3:0] r_tab_width, n_tab_width;
    logic [7:0] r_ch, n_ch;
    logic [3:0] r_cnt, n_cnt;
    logic       r_m_valid, n_m_valid;
    logic [7:0] r_m_data, n_m_data;
    logic       r_m_user, n_m_user;
    logic       r_m_last, n_m_last;

    logic       w_out_free;
    logic [5:0] w_eff_lw;
    logic [3:0] w_eff_tw;
    logic [6:0] w_next_col;
    logic       w_wrap;
    logic       w_cnt_one;

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_m_axis_tlast  = r_m_last;

    // Clamped configuration and cursor advance
    assign w_eff_lw   = (r_line_width == '0) ? 6'd1 :
                        (r_line_width > LINE_MAX) ? LINE_MAX : r_line_width;
    assign w_eff_tw   = (r_tab_width == '0) ? 4'd1 :
                        (r_tab_width > TAB_MAX) ? TAB_MAX : r_tab_width;
    assign w_next_col = {1'b0, r_col} + 7'd1;
    assign w_wrap     = (w_next_col >= {1'b0, w_eff_lw});
    assign w_cnt_one  = (r_cnt == 4'd1);
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_ch         = r_ch;
        n_cnt        = r_cnt;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        n_m_user     = r_m_user;
        n_m_last     = r_m_last;
        n_line_width = r_line_width;
        n_tab_width  = r_tab_width;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH: n_line_width = i_cfg_wdata;
                default:        n_tab_width  = i_cfg_wdata[3:0];
            endcase
        end

        // Output register drains on a transfer
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_ONE;
                    case (i_cmd.op)
                        OP_GOTO: begin
                            n_row = i_cmd.row;
                            n_col = i_cmd.col;
                            n_ch  = addr_cmd(i_cmd.row, i_cmd.col);
                        end
                        OP_NEWLINE: begin
                            n_row = ~r_row;
                            n_col = '0;
                            n_ch  = addr_cmd(~r_row, 6'd0);
                        end
                        OP_RETURN: begin
                            n_col = '0;
                            n_ch  = addr_cmd(r_row, 6'd0);
                        end
                        OP_VTAB: begin
                            n_row = ~r_row;
                            n_ch  = addr_cmd(~r_row, r_col);
                        end
                        OP_FORMFEED: begin
                            n_row = 1'b0;
                            n_col = '0;
                            n_ch  = CMD_CLEAR;
                        end
                        OP_SHIFT_R: n_ch = CMD_SHIFT_R;
                        OP_SHIFT_L: n_ch = CMD_SHIFT_L;
                        OP_BACKSPACE: begin
                            // nothing at all at column zero
                            if (r_col != '0) begin
                                n_col   = r_col - 6'd1;
                                n_state = S_BS_ADDR1;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        OP_TAB: begin
                            n_ch    = SPACE_CHAR;
                            n_cnt   = w_eff_tw;
                            n_state = S_PUT;
                        end
                        default: begin
                            n_ch    = i_cmd.ch;
                            n_cnt   = 4'd1;
                            n_state = S_PUT;
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b0;
                    n_m_data  = r_ch;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_BS_ADDR1: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b0;
                    n_m_data  = addr_cmd(r_row, r_col);
                    n_m_last  = 1'b0;
                    n_state   = S_BS_SPACE;
                end
            end
            S_BS_SPACE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b1;
                    n_m_data  = SPACE_CHAR;
                    n_m_last  = 1'b0;
                    n_state   = S_BS_ADDR2;
                end
            end
            S_BS_ADDR2: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b0;
                    n_m_data  = addr_cmd(r_row, r_col);
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PUT: begin
                // data byte, then advance the cursor
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b1;
                    n_m_data  = r_ch;
                    n_m_last  = !w_wrap && w_cnt_one;
                    if (w_wrap) begin
                        n_col   = '0;
                        n_row   = ~r_row;
                        n_state = S_WRAP;
                    end else begin
                        n_col = w_next_col[5:0];
                        if (w_cnt_one) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cnt = r_cnt - 4'd1;
                        end
                    end
                end
            end
            S_WRAP: begin
                // set-address after a wrap to the other row
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b0;
                    n_m_data  = addr_cmd(r_row, r_col);
                    n_m_last  = w_cnt_one;
                    if (w_cnt_one) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 4'd1;
                        n_state = S_PUT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, cursor, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row        <= 1'b0;
            r_col        <= '0;
            r_line_width <= LINE_WIDTH_RST;
            r_tab_width  <= TAB_WIDTH_RST;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_line_width <= n_line_width;
            r_tab_width  <= n_tab_width;
            r_m_valid    <= n_m_valid;
        end
        r_ch     <= n_ch;
        r_cnt    <= n_cnt;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

endmodule

>>> hw/rtl/cltt_checker.sv
// ----------------------------------------------------------------------------
// cltt_checker: port-level checks of the text terminal
// Watches the output stream over time and is bound to the top level.
// ----------------------------------------------------------------------------
module cltt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // A stalled transfer holds its byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // Nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Command bytes are clear, shift or set-address
    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata == 8'h01 || o_m_axis_tdata == 8'h18 ||
            o_m_axis_tdata == 8'h1C || o_m_axis_tdata[7])
        else $error("unknown command byte");

    // Inside a run the next byte follows without a gap
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside a byte run");

endmodule

bind char_lcd_text_terminal cltt_checker u_cltt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> tb/sv/tb_char_lcd_text_terminal.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_text_terminal: self-checking bench for the LCD text terminal
// Sends print, go-to and shift requests over the input stream. A cursor
// model in the bench predicts the command and data bytes of each request,
// and every output transfer is checked against the oldest predicted byte.
// Both stream sides idle at random. The run covers the width registers at
// their limits and one long output stall that fills the block.
// ----------------------------------------------------------------------------
module tb_char_lcd_text_terminal;
    import cltt_pkg::*;

    // Character codes with terminal handling
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Controller command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW2_OFFSET  = 8'h40;
    localparam logic [7:0] CMD_SHIFT_R  = 8'h1C;
    localparam logic [7:0] CMD_SHIFT_L  = 8'h18;

    // Register select values
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Settle time before a register write or the end of the run
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } t_lcd_xfer;

    bit          i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [5:0]  i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;     // char_code, target_row, target_col
    logic [1:0]  i_s_axis_tuser;     // req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;     // lcd_byte
    logic        o_m_axis_tuser;     // is_data
    logic        o_m_axis_tlast;     // last

    // Cursor and register copies of the bench model
    logic        term_row;
    logic [5:0]  term_col;
    logic [5:0]  line_w_reg;
    logic [3:0]  tab_w_reg;

    t_lcd_xfer   lcd_bytes_due[$];
    t_lcd_xfer   run_bytes[$];
    int          fail_count;

    // Idling controls shared with the sender and receiver processes
    bit          tx_free;
    bit          rx_free;
    int          rx_hold_left;

    char_lcd_text_terminal u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Cursor model
    // ------------------------------------------------------------------------
    function automatic int eff_line_width();
        if (line_w_reg == 6'd0) return 1;
        if (line_w_reg > 6'd40) return 40;
        return int'(line_w_reg);
    endfunction

    function automatic int eff_tab_width();
        if (tab_w_reg == 4'd0) return 1;
        if (tab_w_reg > 4'd8) return 8;
        return int'(tab_w_reg);
    endfunction

    function automatic logic [7:0] set_addr_byte();
        return CMD_SET_ADDR + (term_row ? ROW2_OFFSET : 8'h00) + {2'b00, term_col};
    endfunction

    function automatic void put_byte(input logic is_data, input logic [7:0] b);
        t_lcd_xfer x;
        x.is_data  = is_data;
        x.lcd_byte = b;
        x.last     = 1'b0;
        run_bytes.push_back(x);
    endfunction

    // Step the cursor; wrapping moves to the other row with a set-address
    function automatic void step_cursor();
        int nxt;
        nxt = int'(term_col) + 1;
        if (nxt >= eff_line_width()) begin
            term_col = 6'd0;
            term_row = ~term_row;
            put_byte(RS_CMD, set_addr_byte());
        end else begin
            term_col = 6'(nxt);
        end
    endfunction

    // Expected bus bytes of one request, appended to the due list
    function automatic void predict_lcd_bytes(input logic [1:0] req, input logic [7:0] ch,
                                              input logic [1:0] row, input logic [5:0] col);
        int n;
        run_bytes.delete();
        case (req)
            REQ_PRINT: begin
                case (ch)
                    CH_LF: begin
                        term_row = ~term_row;
                        term_col = 6'd0;
                        put_byte(RS_CMD, set_addr_byte());
                    end
                    CH_CR: begin
                        term_col = 6'd0;
                        put_byte(RS_CMD, set_addr_byte());
                    end
                    CH_VT: begin
                        term_row = ~term_row;
                        put_byte(RS_CMD, set_addr_byte());
                    end
                    CH_FF: begin
                        put_byte(RS_CMD, CMD_CLEAR);
                        term_row = 1'b0;
                        term_col = 6'd0;
                    end
                    CH_BS: begin
                        // nothing at column zero
                        if (term_col != 6'd0) begin
                            term_col = term_col - 6'd1;
                            put_byte(RS_CMD, set_addr_byte());
                            put_byte(RS_DATA, CH_SPACE);
                            put_byte(RS_CMD, set_addr_byte());
                        end
                    end
                    CH_TAB: begin
                        n = eff_tab_width();
                        for (int i = 0; i < n; i++) begin
                            put_byte(RS_DATA, CH_SPACE);
                            step_cursor();
                        end
                    end
                    default: begin
                        put_byte(RS_DATA, ch);
                        step_cursor();
                    end
                endcase
            end
            REQ_GOTO: begin
                term_row = (row == 2'd1) ? 1'b0 : 1'b1;
                term_col = col;
                put_byte(RS_CMD, set_addr_byte());
            end
            REQ_SHIFT_R: put_byte(RS_CMD, CMD_SHIFT_R);
            default:     put_byte(RS_CMD, CMD_SHIFT_L);
        endcase
        if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
        foreach (run_bytes[k]) lcd_bytes_due.push_back(run_bytes[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH at %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_lcd_xfer exp_x;
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            if (lcd_bytes_due.size() == 0) begin
                report_mismatch("unexpected transfer, byte", 0, int'(o_m_axis_tdata));
            end else begin
                exp_x = lcd_bytes_due.pop_front();
                if (o_m_axis_tuser !== exp_x.is_data)
                    report_mismatch("is_data", int'(exp_x.is_data), int'(o_m_axis_tuser));
                if (o_m_axis_tdata !== exp_x.lcd_byte)
                    report_mismatch("lcd_byte", int'(exp_x.lcd_byte), int'(o_m_axis_tdata));
                if (o_m_axis_tlast !== exp_x.last)
                    report_mismatch("last", int'(exp_x.last), int'(o_m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, a forced hold-off when requested
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_free) begin
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends a run in which nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid === 1'b1 && o_s_axis_tready === 1'b1) ||
                (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("** char_lcd_text_terminal: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic int pick_tx_gap();
        int r;
        if (tx_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One request; returns after the transfer on the input side
    task automatic send_req(input logic [1:0] req, input logic [7:0] ch,
                            input logic [1:0] row, input logic [5:0] col);
        int gap;
        gap = pick_tx_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= {col, row, ch};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_lcd_bytes(req, ch, row, col);
    endtask

    task automatic print_char(input logic [7:0] ch);
        send_req(REQ_PRINT, ch, 2'd0, 6'd0);
    endtask

    task automatic goto_pos(input logic [1:0] row, input logic [5:0] col);
        send_req(REQ_GOTO, 8'h00, row, col);
    endtask

    // Random request, mostly printing with a fair share of controls
    task automatic send_random_req();
        logic [7:0] ch;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                ch = 8'($urandom_range(32, 126));
            end else if (r < 80) begin
                case ($urandom_range(0, 5))
                    0: ch = CH_BS;
                    1: ch = CH_TAB;
                    2: ch = CH_LF;
                    3: ch = CH_VT;
                    4: ch = CH_FF;
                    default: ch = CH_CR;
                endcase
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            print_char(ch);
        end else if (r < 85) begin
            goto_pos(2'($urandom_range(0, 3)),
                     ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 39)));
        end else begin
            send_req(($urandom_range(0, 1) == 0) ? REQ_SHIFT_R : REQ_SHIFT_L,
                     8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                     6'($urandom_range(0, 63)));
        end
    endtask

    // Wait until every predicted byte is out and the block has settled
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (lcd_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_LINE_WIDTH) line_w_reg = value;
        else tab_w_reg = value[3:0];
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Plain characters at the byte extremes, default widths
    task automatic test_print_basics();
        print_char(8'h48);
        print_char(8'h00);
        print_char(8'hFF);
        print_char(8'h7F);
    endtask

    // Terminal controls, including backspace with the cursor at column zero
    task automatic test_controls();
        print_char(CH_BS);
        print_char(CH_CR);
        print_char(CH_BS);
        print_char(CH_TAB);
        print_char(CH_LF);
        print_char(CH_VT);
        print_char(CH_FF);
    endtask

    // Go-to with odd rows and columns past the width, then shifts
    task automatic test_goto_shift();
        goto_pos(2'd2, 6'd15);
        print_char(8'h78);
        goto_pos(2'd1, 6'd39);
        print_char(8'h79);
        goto_pos(2'd3, 6'd63);
        print_char(CH_BS);
        goto_pos(2'd0, 6'd0);
        send_req(REQ_SHIFT_R, 8'h00, 2'd0, 6'd0);
        send_req(REQ_SHIFT_L, 8'hFF, 2'd3, 6'd63);
    endtask

    // Width registers at their limits and beyond
    task automatic test_width_limits();
        logic [5:0] lw_set[5] = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd41};
        logic [5:0] tw_set[5] = '{6'd8, 6'd1, 6'd0, 6'd15, 6'd9};
        for (int s = 0; s < 5; s++) begin
            write_reg(CFG_LINE_WIDTH, lw_set[s]);
            write_reg(CFG_TAB_WIDTH, tw_set[s]);
            print_char(CH_TAB);
            goto_pos(2'd1, 6'd38);
            repeat (6) send_random_req();
        end
    endtask

    // Random traffic over several random settings, one phase without idling
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_LINE_WIDTH, ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                                                  : 6'($urandom_range(4, 20)));
            write_reg(CFG_TAB_WIDTH, 6'($urandom_range(0, 15)));
            tx_free = (p == 2);
            rx_free = (p == 2);
            repeat (25) send_random_req();
        end
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    // Long output hold-off while long tabs keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(CFG_LINE_WIDTH, 6'd3);
        write_reg(CFG_TAB_WIDTH, 6'd8);
        tx_free = 1'b1;
        rx_hold_left = 150;
        repeat (8) print_char(CH_TAB);
        repeat (4) send_random_req();
        tx_free = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        fail_count      = 0;
        tx_free         = 1'b0;
        rx_free         = 1'b0;
        rx_hold_left    = 0;
        term_row        = 1'b0;
        term_col        = 6'd0;
        line_w_reg      = LINE_WIDTH_RST;
        tab_w_reg       = TAB_WIDTH_RST;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_LINE_WIDTH;
        i_cfg_wdata     <= 6'd0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 16'd0;
        i_s_axis_tuser  <= REQ_PRINT;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_print_basics();
        test_controls();
        test_goto_shift();
        test_width_limits();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        if (fail_count == 0) begin
            $display("** char_lcd_text_terminal: PASSED **");
        end else begin
            $display("** char_lcd_text_terminal: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cltt_pkg.sv
hw/rtl/cltt_front.sv
hw/rtl/cltt_queue.sv
hw/rtl/cltt_back.sv
hw/rtl/char_lcd_text_terminal.sv
hw/rtl/cltt_checker.sv
tb/sv/tb_char_lcd_text_terminal.sv
